/* src/cvm_pkg.sv */
package cvm_pkg;

  localparam int CFG_W    = 40;
  localparam int CFG_IDX_W = 2;
  localparam int STRESS_W = 48;
  localparam int RAD_W    = 102;
  localparam int ROOT_W   = 51;
  localparam int REM_W    = 54;

  localparam logic [CFG_IDX_W-1:0] REG_LAME_LAMBDA   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR_MODULUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_GAIN  = 2'd2;

  typedef struct packed {
    logic signed [31:0] eps_xx;
    logic signed [31:0] eps_yy;
    logic signed [31:0] eps_zz;
    logic signed [31:0] eps_xy;
    logic signed [31:0] eps_yz;
    logic signed [31:0] eps_zx;
    logic [15:0]        flaw_density;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               on_boundary;
  } node_t;

  typedef struct packed {
    logic [CFG_W-1:0] lame_lambda;
    logic [CFG_W-1:0] shear_modulus;
    logic [CFG_W-1:0] release_gain;
  } cfg_t;

  typedef logic [5:0][STRESS_W-1:0] svec_t;

endpackage

/* src/cvm_in_if.sv */
interface cvm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eps_xx;
  logic signed [31:0] eps_yy;
  logic signed [31:0] eps_zz;
  logic signed [31:0] eps_xy;
  logic signed [31:0] eps_yz;
  logic signed [31:0] eps_zx;
  logic [15:0]        flaw_density;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic               on_boundary;

  modport source (
    output valid, eps_xx, eps_yy, eps_zz, eps_xy, eps_yz, eps_zx,
    output flaw_density, dir_x, dir_y, dir_z, on_boundary,
    input  ready
  );
  modport sink (
    input  valid, eps_xx, eps_yy, eps_zz, eps_xy, eps_yz, eps_zx,
    input  flaw_density, dir_x, dir_y, dir_z, on_boundary,
    output ready
  );
endinterface

/* src/cvm_out_if.sv */
interface cvm_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] stress_xx;
  logic signed [47:0] stress_yy;
  logic signed [47:0] stress_zz;
  logic signed [47:0] shear_xy;
  logic signed [47:0] shear_yz;
  logic signed [47:0] shear_zx;
  logic [47:0]        equivalent_stress;

  modport source (
    output valid, stress_xx, stress_yy, stress_zz, shear_xy, shear_yz, shear_zx,
    output equivalent_stress,
    input  ready
  );
  modport sink (
    input  valid, stress_xx, stress_yy, stress_zz, shear_xy, shear_yz, shear_zx,
    input  equivalent_stress,
    output ready
  );
endinterface

/* src/cvm_hooke.sv */
module cvm_hooke (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  cvm_pkg::node_t   in_node,
  input  cvm_pkg::cfg_t    cfg,
  output logic             out_valid,
  output cvm_pkg::svec_t   out_s
);

  logic               v1_r, v2_r, v3_r, v4_r;
  logic               b1_r, b2_r, b3_r;
  logic signed [31:0] e1_r [6];
  logic signed [31:0] pp1_r [6];
  logic signed [33:0] tr1_r;
  logic [55:0]        dg1_r;

  logic signed [54:0] tl_lo_r, tl_hi_r;
  logic signed [52:0] em_lo_r [6];
  logic signed [52:0] em_hi_r [6];
  logic signed [60:0] rl_r [6];
  logic signed [60:0] rh_r [6];

  logic signed [75:0] el_r [6];
  logic signed [88:0] rel_r [6];
  cvm_pkg::svec_t     s_r;

  logic signed [33:0] tr1_nxt;
  logic signed [31:0] pp1_nxt [6];
  logic signed [74:0] tlam;
  logic signed [72:0] em [6];
  logic signed [75:0] el_nxt [6];
  logic signed [88:0] rel_nxt [6];
  logic signed [89:0] acc [6];

  always_comb begin
    tr1_nxt = 34'(in_node.eps_xx) + 34'(in_node.eps_yy) + 34'(in_node.eps_zz);
    pp1_nxt[0] = 32'(in_node.dir_x) * 32'(in_node.dir_x);
    pp1_nxt[1] = 32'(in_node.dir_y) * 32'(in_node.dir_y);
    pp1_nxt[2] = 32'(in_node.dir_z) * 32'(in_node.dir_z);
    pp1_nxt[3] = 32'(in_node.dir_x) * 32'(in_node.dir_y);
    pp1_nxt[4] = 32'(in_node.dir_y) * 32'(in_node.dir_z);
    pp1_nxt[5] = 32'(in_node.dir_z) * 32'(in_node.dir_x);
  end

  always_comb begin
    tlam = (75'(tl_hi_r) <<< 20) + 75'(tl_lo_r);
    for (int i = 0; i < 6; i++) begin
      em[i]      = (73'(em_hi_r[i]) <<< 20) + 73'(em_lo_r[i]);
      el_nxt[i]  = (76'(em[i]) <<< 1) + ((i < 3) ? 76'(tlam) : 76'sd0);
      rel_nxt[i] = (89'(rh_r[i]) <<< 28) + 89'(rl_r[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      acc[i] = (90'(el_r[i]) <<< 13) - 90'(rel_r[i]) + (90'sd1 <<< 44);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r[0] <= in_node.eps_xx;
      e1_r[1] <= in_node.eps_yy;
      e1_r[2] <= in_node.eps_zz;
      e1_r[3] <= in_node.eps_xy;
      e1_r[4] <= in_node.eps_yz;
      e1_r[5] <= in_node.eps_zx;
      pp1_r   <= pp1_nxt;
      tr1_r   <= tr1_nxt;
      dg1_r   <= 56'(in_node.flaw_density) * 56'(cfg.release_gain);
      b1_r    <= in_node.on_boundary;

      tl_lo_r <= tr1_r * $signed({1'b0, cfg.lame_lambda[19:0]});
      tl_hi_r <= tr1_r * $signed({1'b0, cfg.lame_lambda[39:20]});
      for (int i = 0; i < 6; i++) begin
        em_lo_r[i] <= e1_r[i] * $signed({1'b0, cfg.shear_modulus[19:0]});
        em_hi_r[i] <= e1_r[i] * $signed({1'b0, cfg.shear_modulus[39:20]});
        rl_r[i]    <= pp1_r[i] * $signed({1'b0, dg1_r[27:0]});
        rh_r[i]    <= pp1_r[i] * $signed({1'b0, dg1_r[55:28]});
      end
      b2_r <= b1_r;

      el_r  <= el_nxt;
      rel_r <= rel_nxt;
      b3_r  <= b2_r;

      for (int i = 0; i < 6; i++) begin
        s_r[i] <= b3_r ? '0 : 48'($signed(acc[i][89:45]));
      end
    end
  end

  assign out_valid = v4_r;
  assign out_s     = s_r;

endmodule

/* src/cvm_square.sv */
module cvm_square (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  cvm_pkg::svec_t                in_s,
  output logic                          out_valid,
  output logic [cvm_pkg::RAD_W-1:0]     out_rad,
  output cvm_pkg::svec_t                out_s
);

  logic [4:0]          v_r;
  cvm_pkg::svec_t      s_r [5];
  logic [48:0]         m_r [6];
  logic [49:0]         hh_r [6];
  logic [48:0]         hl_r [6];
  logic [47:0]         ll_r [6];
  logic [100:0]        q_r [6];
  logic [101:0]        a_r, b_r;
  logic [cvm_pkg::RAD_W-1:0] rad_r;

  logic signed [48:0]  d [6];
  logic [97:0]         sq [6];
  logic [101:0]        vm;

  always_comb begin
    d[0] = 49'($signed(in_s[0])) - 49'($signed(in_s[1]));
    d[1] = 49'($signed(in_s[1])) - 49'($signed(in_s[2]));
    d[2] = 49'($signed(in_s[2])) - 49'($signed(in_s[0]));
    d[3] = 49'($signed(in_s[3]));
    d[4] = 49'($signed(in_s[4]));
    d[5] = 49'($signed(in_s[5]));
    for (int i = 0; i < 6; i++) begin
      sq[i] = (98'(hh_r[i]) << 48) + (98'(hl_r[i]) << 25) + 98'(ll_r[i]);
    end
    vm = a_r + b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0] <= in_s;
      for (int k = 1; k < 5; k++) begin
        s_r[k] <= s_r[k-1];
      end
      for (int i = 0; i < 6; i++) begin
        m_r[i]  <= d[i][48] ? 49'(-d[i]) : 49'(d[i]);
        hh_r[i] <= 50'(m_r[i][48:24]) * 50'(m_r[i][48:24]);
        hl_r[i] <= 49'(m_r[i][48:24]) * 49'(m_r[i][23:0]);
        ll_r[i] <= 48'(m_r[i][23:0]) * 48'(m_r[i][23:0]);
        q_r[i]  <= (i < 3) ? 101'(sq[i]) : (101'(sq[i]) << 2) + (101'(sq[i]) << 1);
      end
      a_r   <= 102'(q_r[0]) + 102'(q_r[1]) + 102'(q_r[2]);
      b_r   <= 102'(q_r[3]) + 102'(q_r[4]) + 102'(q_r[5]);
      rad_r <= {1'b0, vm[101:1]};
    end
  end

  assign out_valid = v_r[4];
  assign out_rad   = rad_r;
  assign out_s     = s_r[4];

endmodule

/* src/cvm_sqrt.sv */
module cvm_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [cvm_pkg::RAD_W-1:0]     in_rad,
  input  cvm_pkg::svec_t                in_s,
  output logic                          out_valid,
  output logic [cvm_pkg::ROOT_W-1:0]    out_root,
  output cvm_pkg::svec_t                out_s
);

  localparam int NS = cvm_pkg::ROOT_W;

  logic                          v_r   [NS];
  logic [cvm_pkg::RAD_W-1:0]     n_r   [NS];
  logic [cvm_pkg::REM_W-1:0]     rem_r [NS];
  logic [cvm_pkg::ROOT_W-1:0]    q_r   [NS];
  cvm_pkg::svec_t                s_r   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_st
    logic                          src_v;
    logic [cvm_pkg::RAD_W-1:0]     src_n;
    logic [cvm_pkg::REM_W-1:0]     src_rem;
    logic [cvm_pkg::ROOT_W-1:0]    src_q;
    cvm_pkg::svec_t                src_s;
    logic [cvm_pkg::REM_W-1:0]     sh, trial;

    if (k == 0) begin : g_first
      assign src_v   = in_valid;
      assign src_n   = in_rad;
      assign src_rem = '0;
      assign src_q   = '0;
      assign src_s   = in_s;
    end else begin : g_next
      assign src_v   = v_r[k-1];
      assign src_n   = n_r[k-1];
      assign src_rem = rem_r[k-1];
      assign src_q   = q_r[k-1];
      assign src_s   = s_r[k-1];
    end

    assign sh    = {src_rem[cvm_pkg::REM_W-3:0], src_n[cvm_pkg::RAD_W-1 -: 2]};
    assign trial = {1'b0, src_q, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= src_n << 2;
        s_r[k] <= src_s;
        if (sh >= trial) begin
          rem_r[k] <= sh - trial;
          q_r[k]   <= {src_q[cvm_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[k] <= sh;
          q_r[k]   <= {src_q[cvm_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_root  = q_r[NS-1];
  assign out_s     = s_r[NS-1];

endmodule

/* src/crack_stress_von_mises_unit_top.sv */
// Latency: 60 register stages from input to output.
// Throughput: one node per cycle; the whole pipeline holds while a result waits.
// The 51-stage square root pipeline, one root bit per stage, sets most of the latency;
// the stress and squaring stages add the other nine.
// Reset is synchronous and active low: it clears every valid bit and the three
// configuration registers to zero.
module crack_stress_von_mises_unit_top (
  input  logic                              clk,
  input  logic                              rst_n,
  cvm_in_if.sink                            in_ch,
  cvm_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [cvm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cvm_pkg::CFG_W-1:0]         cfg_data
);

  cvm_pkg::cfg_t                  cfg_r;
  cvm_pkg::node_t                 node;
  logic                           en;
  logic                           h_valid, q_valid, r_valid;
  cvm_pkg::svec_t                 h_s, q_s, r_s;
  logic [cvm_pkg::RAD_W-1:0]      rad;
  logic [cvm_pkg::ROOT_W-1:0]     root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cvm_pkg::REG_LAME_LAMBDA:   cfg_r.lame_lambda   <= cfg_data;
        cvm_pkg::REG_SHEAR_MODULUS: cfg_r.shear_modulus <= cfg_data;
        cvm_pkg::REG_RELEASE_GAIN:  cfg_r.release_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en          = !r_valid || out_ch.ready;
  assign in_ch.ready = en;

  assign node = '{
    eps_xx:       in_ch.eps_xx,
    eps_yy:       in_ch.eps_yy,
    eps_zz:       in_ch.eps_zz,
    eps_xy:       in_ch.eps_xy,
    eps_yz:       in_ch.eps_yz,
    eps_zx:       in_ch.eps_zx,
    flaw_density: in_ch.flaw_density,
    dir_x:        in_ch.dir_x,
    dir_y:        in_ch.dir_y,
    dir_z:        in_ch.dir_z,
    on_boundary:  in_ch.on_boundary
  };

  cvm_hooke u_hooke (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_node   (node),
    .cfg       (cfg_r),
    .out_valid (h_valid),
    .out_s     (h_s)
  );

  cvm_square u_square (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (h_valid),
    .in_s      (h_s),
    .out_valid (q_valid),
    .out_rad   (rad),
    .out_s     (q_s)
  );

  cvm_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (q_valid),
    .in_rad    (rad),
    .in_s      (q_s),
    .out_valid (r_valid),
    .out_root  (root),
    .out_s     (r_s)
  );

  assign out_ch.valid             = r_valid;
  assign out_ch.stress_xx         = $signed(r_s[0]);
  assign out_ch.stress_yy         = $signed(r_s[1]);
  assign out_ch.stress_zz         = $signed(r_s[2]);
  assign out_ch.shear_xy          = $signed(r_s[3]);
  assign out_ch.shear_yz          = $signed(r_s[4]);
  assign out_ch.shear_zx          = $signed(r_s[5]);
  assign out_ch.equivalent_stress =
    (root[cvm_pkg::ROOT_W-1:cvm_pkg::STRESS_W] != '0) ? '1 : root[cvm_pkg::STRESS_W-1:0];

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam logic [cvm_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int LATENCY = 60;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [127:0] S48_MAX = (128'sd1 <<< 47) - 1;
  localparam logic signed [127:0] S48_MIN = -(128'sd1 <<< 47);
  localparam logic [cvm_pkg::CFG_W-1:0] CFG_MAX = {cvm_pkg::CFG_W{1'b1}};

  typedef struct packed {
    cvm_pkg::svec_t stress;
    logic [47:0]    equivalent;
  } stress_rec_t;

  class node_stress_ledger;
    logic [cvm_pkg::CFG_W-1:0] lambda_reg, mu_reg, gain_reg;
    stress_rec_t               awaited[$];
    int                        errors;

    function new();
      lambda_reg = '0;
      mu_reg     = '0;
      gain_reg   = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [cvm_pkg::CFG_IDX_W-1:0] idx, logic [cvm_pkg::CFG_W-1:0] val);
      case (idx)
        cvm_pkg::REG_LAME_LAMBDA:   lambda_reg = val;
        cvm_pkg::REG_SHEAR_MODULUS: mu_reg = val;
        cvm_pkg::REG_RELEASE_GAIN:  gain_reg = val;
        default: ;
      endcase
    endfunction

    function logic signed [127:0] relieve(logic signed [127:0] elastic,
                                          logic signed [127:0] pp,
                                          logic signed [127:0] dg);
      logic signed [127:0] acc;
      acc = (elastic <<< 13) - pp * dg + (128'sd1 <<< 44);
      acc = acc >>> 45;
      if (acc > S48_MAX) acc = S48_MAX;
      if (acc < S48_MIN) acc = S48_MIN;
      return acc;
    endfunction

    function stress_rec_t hooke_release_stress(cvm_pkg::node_t n);
      stress_rec_t         r;
      logic signed [127:0] e[6], d[3], s[6];
      logic signed [127:0] lam, mu2, dg, trace, vm, diff;
      logic [127:0]        t, root, c;
      r = '0;
      if (n.on_boundary) return r;
      e[0] = n.eps_xx; e[1] = n.eps_yy; e[2] = n.eps_zz;
      e[3] = n.eps_xy; e[4] = n.eps_yz; e[5] = n.eps_zx;
      d[0] = n.dir_x; d[1] = n.dir_y; d[2] = n.dir_z;
      lam = lambda_reg;
      mu2 = mu_reg;
      mu2 = mu2 * 2;
      dg = n.flaw_density;
      dg = dg * gain_reg;
      trace = e[0] + e[1] + e[2];
      for (int i = 0; i < 3; i++)
        s[i] = relieve(trace * lam + e[i] * mu2, d[i] * d[i], dg);
      s[3] = relieve(e[3] * mu2, d[0] * d[1], dg);
      s[4] = relieve(e[4] * mu2, d[1] * d[2], dg);
      s[5] = relieve(e[5] * mu2, d[2] * d[0], dg);
      vm = 0;
      for (int i = 0; i < 3; i++) begin
        diff = s[i] - s[(i + 1) % 3];
        vm += diff * diff;
      end
      for (int i = 3; i < 6; i++) vm += 6 * s[i] * s[i];
      t = vm >>> 1;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        c = root | (128'd1 << b);
        if (c * c <= t) root = c;
      end
      for (int i = 0; i < 6; i++) r.stress[i] = s[i][47:0];
      r.equivalent = (root > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : root[47:0];
      return r;
    endfunction

    function void note_node(cvm_pkg::node_t n);
      awaited.insert(awaited.size(), hooke_release_stress(n));
    endfunction

    task report(string what, logic [47:0] got, logic [47:0] want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_result(stress_rec_t got);
      stress_rec_t want;
      string names[6] = '{"stress_xx", "stress_yy", "stress_zz",
                          "shear_xy", "shear_yz", "shear_zx"};
      if (awaited.size() == 0) begin
        report("unexpected transaction", got.equivalent, '0);
        return;
      end
      want = awaited.pop_front();
      for (int i = 0; i < 6; i++)
        if (got.stress[i] !== want.stress[i]) report(names[i], got.stress[i], want.stress[i]);
      if (got.equivalent !== want.equivalent)
        report("equivalent_stress", got.equivalent, want.equivalent);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [cvm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cvm_pkg::CFG_W-1:0] cfg_data = '0;
  int tx_idle_pct, rx_idle_pct;
  int hold_request = 0;
  int cycles = 0;
  node_stress_ledger ledger = new();

  cvm_in_if in_ch();
  cvm_out_if out_ch();

  crack_stress_von_mises_unit_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The receiver counts out a requested long hold itself, then idles at random.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    stress_rec_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.stress = {out_ch.shear_zx, out_ch.shear_yz, out_ch.shear_xy,
                    out_ch.stress_zz, out_ch.stress_yy, out_ch.stress_xx};
      got.equivalent = out_ch.equivalent_stress;
      ledger.check_result(got);
    end
  end

  task write_reg(logic [cvm_pkg::CFG_IDX_W-1:0] idx, logic [cvm_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    ledger.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task set_moduli(logic [cvm_pkg::CFG_W-1:0] lam, logic [cvm_pkg::CFG_W-1:0] mu,
                  logic [cvm_pkg::CFG_W-1:0] gain);
    write_reg(cvm_pkg::REG_LAME_LAMBDA, lam);
    write_reg(cvm_pkg::REG_SHEAR_MODULUS, mu);
    write_reg(cvm_pkg::REG_RELEASE_GAIN, gain);
  endtask

  task push_node(cvm_pkg::node_t n);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.eps_xx = n.eps_xx;
    in_ch.eps_yy = n.eps_yy;
    in_ch.eps_zz = n.eps_zz;
    in_ch.eps_xy = n.eps_xy;
    in_ch.eps_yz = n.eps_yz;
    in_ch.eps_zx = n.eps_zx;
    in_ch.flaw_density = n.flaw_density;
    in_ch.dir_x = n.dir_x;
    in_ch.dir_y = n.dir_y;
    in_ch.dir_z = n.dir_z;
    in_ch.on_boundary = n.on_boundary;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    ledger.note_node(n);
  endtask

  task drain;
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (ledger.awaited.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function logic signed [31:0] pick_strain();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1, 2: return $signed($urandom_range(4000)) - 2000;
      default: return $urandom;
    endcase
  endfunction

  function logic signed [15:0] pick_dir();
    case ($urandom_range(4))
      0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      1: return 16'($signed($urandom_range(36000)) - 18000);
      default: return 16'($urandom);
    endcase
  endfunction

  function cvm_pkg::node_t random_node();
    cvm_pkg::node_t n;
    n.eps_xx = pick_strain();
    n.eps_yy = pick_strain();
    n.eps_zz = pick_strain();
    n.eps_xy = pick_strain();
    n.eps_yz = pick_strain();
    n.eps_zx = pick_strain();
    case ($urandom_range(3))
      0: n.flaw_density = 16'($urandom);
      1: n.flaw_density = 16'd32768;
      default: n.flaw_density = 16'($urandom_range(32768));
    endcase
    n.dir_x = pick_dir();
    n.dir_y = pick_dir();
    n.dir_z = pick_dir();
    n.on_boundary = ($urandom_range(9) == 0);
    return n;
  endfunction

  task run_random(int count);
    repeat (count) push_node(random_node());
  endtask

  initial begin
    cvm_pkg::node_t n;
    tx_idle_pct = 9;
    rx_idle_pct = 87;
    in_ch.valid = 1'b0;
    in_ch.eps_xx = '0; in_ch.eps_yy = '0; in_ch.eps_zz = '0;
    in_ch.eps_xy = '0; in_ch.eps_yz = '0; in_ch.eps_zx = '0;
    in_ch.flaw_density = '0;
    in_ch.dir_x = '0; in_ch.dir_y = '0; in_ch.dir_z = '0;
    in_ch.on_boundary = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Registers still hold their reset value of zero for the first node.
    n = random_node();
    n.on_boundary = 1'b0;
    push_node(n);
    drain();

    set_moduli(40'd30_000_000_000, 40'd25_000_000_000, 40'd5_000_000);
    write_reg(REG_SPARE, CFG_MAX);
    n = '0;
    push_node(n);
    n.eps_xx = 32'sh7FFF_FFFF; n.eps_yy = 32'sh7FFF_FFFF; n.eps_zz = 32'sh7FFF_FFFF;
    n.eps_xy = 32'sh7FFF_FFFF; n.eps_yz = 32'sh7FFF_FFFF; n.eps_zx = 32'sh7FFF_FFFF;
    push_node(n);
    n.eps_xx = 32'sh8000_0000; n.eps_yy = 32'sh8000_0000; n.eps_zz = 32'sh8000_0000;
    n.eps_xy = 32'sh8000_0000; n.eps_yz = 32'sh8000_0000; n.eps_zx = 32'sh8000_0000;
    push_node(n);
    n.eps_yy = 32'sh7FFF_FFFF;
    n.flaw_density = 16'd32768;
    n.dir_x = 16'sh7FFF; n.dir_y = 16'sh8000; n.dir_z = 16'sh0000;
    push_node(n);
    n.flaw_density = 16'hFFFF;
    n.dir_x = 16'sh8000; n.dir_y = 16'sh8000; n.dir_z = 16'sh8000;
    push_node(n);
    n.dir_x = 16'sh7FFF; n.dir_y = 16'sh7FFF; n.dir_z = 16'sh7FFF;
    push_node(n);
    n.dir_x = 16'sd100; n.dir_y = -16'sd3; n.dir_z = 16'sd0;
    push_node(n);
    n.on_boundary = 1'b1;
    push_node(n);
    for (int i = 0; i < 12; i++) push_node(random_node());
    drain();

    set_moduli(CFG_MAX, CFG_MAX, CFG_MAX);
    for (int i = 0; i < 4; i++) begin
      n = random_node();
      n.on_boundary = 1'b0;
      n.flaw_density = i[0] ? 16'hFFFF : 16'd0;
      push_node(n);
    end
    run_random(200);
    drain();

    tx_idle_pct = 87;
    rx_idle_pct = 9;
    set_moduli(40'd0, 40'd0, CFG_MAX);
    run_random(120);
    drain();
    set_moduli(40'd1, 40'd1, 40'd0);
    run_random(120);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_moduli({8'($urandom), 32'($urandom)}, {8'($urandom), 32'($urandom)},
               {8'($urandom), 32'($urandom)});
    hold_request = 400;
    run_random(300);
    drain();

    if (ledger.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
